/* hw/rtl/jhtd_pkg.sv */
// Shared types and constants for the JPEG Huffman table decoder.
`timescale 1ns / 1ps
package jhtd_pkg;

  localparam int MAX_LEN    = 16;
  localparam int LEN_IDX_W  = 4;
  localparam int CODE_W     = 17;
  localparam int POS_W      = 9;
  localparam int SUM_W      = 12;
  localparam int SYM_DEPTH  = 256;

  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_BIT   = 1'b1;

  typedef enum logic [1:0] {
    ST_SYMBOL   = 2'd0,
    ST_LOADED   = 2'd1,
    ST_REJECTED = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BUILD = 5'b00010,
    S_DEC_A = 5'b00100,
    S_DEC_B = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic build;
    logic dec_a;
    logic dec_b;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_build;
    logic go_emit;
    logic go_decode;
    logic build_last;
    logic dec_hit;
    logic dec_miss;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/jhtd_ctrl.sv */
// Sequencing state machine for table load, code build and bit decode.
`timescale 1ns / 1ps
module jhtd_ctrl
  import jhtd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          priority if (sts.go_build) state_nxt = S_BUILD;
          else if (sts.go_emit)      state_nxt = S_EMIT;
          else if (sts.go_decode)    state_nxt = S_DEC_A;
          else                       state_nxt = S_IDLE;
        end
      end
      S_BUILD: begin
        cmd.build = 1'b1;
        if (sts.build_last) state_nxt = S_EMIT;
      end
      S_DEC_A: begin
        cmd.dec_a = 1'b1;
        state_nxt = S_DEC_B;
      end
      S_DEC_B: begin
        cmd.dec_b = 1'b1;
        state_nxt = (sts.dec_hit || sts.dec_miss) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/jhtd_datapath.sv */
// Table storage, canonical code builder, bit decoder and output register.
`timescale 1ns / 1ps
module jhtd_datapath
  import jhtd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic          kind,
  input  logic [7:0]    table_byte,
  input  logic          code_bit,
  input  logic          out_ready,
  output logic          out_valid,
  output status_t       out_status,
  output logic [7:0]    out_symbol,
  output logic [8:0]    out_bytes
);

  // load bookkeeping
  logic [POS_W-1:0]     pos_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 table_valid_r;
  logic [15:0]          prefix_r;
  logic [LEN_IDX_W-1:0] plen_r;
  logic                 bit_r;

  // per-length tables
  logic [7:0]           lc_r   [MAX_LEN];
  logic [CODE_W-1:0]    maxc_r [MAX_LEN];
  logic [7:0]           fi_r   [MAX_LEN];

  // builder
  logic [LEN_IDX_W-1:0] len_idx_r;
  logic [CODE_W-1:0]    code_r;
  logic [7:0]           idx_r;
  logic [CODE_W-1:0]    endv_r;

  // decode stage registers
  logic [15:0]          p_r;
  logic [15:0]          pshift_r;
  logic [CODE_W-1:0]    start_r;
  logic [CODE_W-1:0]    maxcq_r;
  logic                 fitnz_r;
  logic [7:0]           fiq_r;
  logic                 k16_r;

  // symbol memory
  logic [7:0]           sym_mem [SYM_DEPTH];
  logic [7:0]           rd_r;

  // pending result and output register
  status_t              res_status_r;
  logic [8:0]           res_bytes_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [7:0]           out_symbol_r;
  logic [8:0]           out_bytes_r;

  // load decode
  logic                 is_table, is_bit, first_byte, in_counts, last_count;
  logic [SUM_W-1:0]     sum_base, sum_add;
  logic                 sum_over, sum_zero;
  logic [7:0]           sym_at;
  logic                 sym_last;
  logic                 build_start;

  assign is_table   = (kind == KIND_TABLE);
  assign is_bit     = (kind == KIND_BIT);
  assign first_byte = (pos_r == '0);
  assign in_counts  = (pos_r < POS_W'(MAX_LEN));
  assign last_count = (pos_r == POS_W'(MAX_LEN - 1));
  assign sum_base   = first_byte ? '0 : sum_r;
  assign sum_add    = sum_base + SUM_W'(table_byte);
  assign sum_over   = (sum_add[SUM_W-1:8] != '0);
  assign sum_zero   = (sum_add == '0);
  assign sym_at     = 8'(pos_r - POS_W'(MAX_LEN));
  assign sym_last   = ({1'b0, sym_at} + 9'd1) >= sum_r[8:0];
  assign build_start = is_table &&
                       ((in_counts && last_count && sum_zero) || (!in_counts && sym_last));

  // shared table read port
  logic [LEN_IDX_W-1:0] rd_idx;
  logic [7:0]           rd_lc, rd_fi;
  logic [CODE_W-1:0]    rd_maxc;

  assign rd_idx  = cmd.build ? len_idx_r : plen_r;
  assign rd_lc   = lc_r[rd_idx];
  assign rd_fi   = fi_r[rd_idx];
  assign rd_maxc = maxc_r[rd_idx];

  // one code length per build cycle
  logic [4:0]           bl_len;
  logic [CODE_W-1:0]    bl_cap, bl_rem, bl_sum;
  logic [7:0]           bl_fit;

  assign bl_len = {1'b0, len_idx_r} + 5'd1;
  assign bl_cap = CODE_W'(1) << bl_len;
  assign bl_rem = bl_cap - code_r;
  always_comb begin
    if (code_r < bl_cap) begin
      bl_fit = (CODE_W'(rd_lc) < bl_rem) ? rd_lc : bl_rem[7:0];
    end else begin
      bl_fit = '0;
    end
  end
  assign bl_sum = code_r + CODE_W'(bl_fit);

  // decode compare
  logic [15:0]          p_nxt;
  logic [CODE_W-1:0]    p_ext, diff;
  logic                 dec_hit, dec_miss;
  logic [7:0]           dec_at;

  assign p_nxt    = {prefix_r[14:0], bit_r};
  assign p_ext    = CODE_W'(p_r);
  assign dec_hit  = fitnz_r && (p_ext >= start_r) && (p_ext < maxcq_r);
  assign dec_miss = !dec_hit && (k16_r || (CODE_W'(pshift_r) >= endv_r));
  assign diff     = p_ext - start_r;
  assign dec_at   = fiq_r + diff[7:0];

  assign sts.go_build   = build_start;
  assign sts.go_emit    = (is_table && in_counts && last_count && sum_over) ||
                          (is_bit && !table_valid_r);
  assign sts.go_decode  = is_bit && table_valid_r;
  assign sts.build_last = (len_idx_r == LEN_IDX_W'(MAX_LEN - 1));
  assign sts.dec_hit    = dec_hit;
  assign sts.dec_miss   = dec_miss;
  assign sts.out_free   = !out_valid_r || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      sum_r         <= '0;
      table_valid_r <= 1'b0;
      prefix_r      <= '0;
      plen_r        <= '0;
      len_idx_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.take && is_table) begin
        if (first_byte) begin
          table_valid_r <= 1'b0;
          prefix_r      <= '0;
          plen_r        <= '0;
        end
        if (in_counts) begin
          if (last_count && (sum_over || sum_zero)) begin
            pos_r <= '0;
            sum_r <= sum_over ? '0 : sum_add;
          end else begin
            sum_r <= sum_add;
            pos_r <= pos_r + 1'b1;
          end
        end else begin
          pos_r <= sym_last ? '0 : pos_r + 1'b1;
        end
      end
      if (cmd.take && is_bit && !table_valid_r) begin
        prefix_r <= '0;
        plen_r   <= '0;
      end
      if (build_start && cmd.take) begin
        len_idx_r <= '0;
      end
      if (cmd.build) begin
        len_idx_r <= len_idx_r + 1'b1;
        if (sts.build_last) table_valid_r <= 1'b1;
      end
      if (cmd.dec_b) begin
        if (dec_hit || dec_miss) begin
          prefix_r <= '0;
          plen_r   <= '0;
        end else begin
          prefix_r <= p_r;
          plen_r   <= plen_r + 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // table and builder payload
  always_ff @(posedge clk) begin
    if (cmd.take && is_table && in_counts) begin
      lc_r[pos_r[LEN_IDX_W-1:0]] <= table_byte;
    end else if (cmd.build) begin
      lc_r[len_idx_r]   <= bl_fit;
      maxc_r[len_idx_r] <= bl_sum;
      fi_r[len_idx_r]   <= idx_r;
    end
    if (cmd.take && build_start) begin
      code_r <= '0;
      idx_r  <= '0;
      endv_r <= '0;
    end else if (cmd.build) begin
      idx_r  <= idx_r + rd_lc;
      code_r <= sts.build_last ? bl_sum : (bl_sum << 1);
      // end of the assigned code space, left aligned to the longest length
      if (bl_fit != '0) endv_r <= bl_sum << (4'd15 - len_idx_r);
    end
  end

  // decode stage payload
  always_ff @(posedge clk) begin
    if (cmd.take && is_bit) bit_r <= code_bit;
    if (cmd.dec_a) begin
      p_r      <= p_nxt;
      pshift_r <= p_nxt << (4'd15 - plen_r);
      start_r  <= rd_maxc - CODE_W'(rd_lc);
      maxcq_r  <= rd_maxc;
      fitnz_r  <= (rd_lc != '0);
      fiq_r    <= rd_fi;
      k16_r    <= (plen_r == LEN_IDX_W'(MAX_LEN - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && is_table && !in_counts) sym_mem[sym_at] <= table_byte;
    if (cmd.dec_b) rd_r <= sym_mem[dec_at];
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.take && is_table && in_counts && last_count) begin
      res_status_r <= sum_over ? ST_REJECTED : ST_LOADED;
      res_bytes_r  <= 9'(MAX_LEN);
    end else if (cmd.take && is_table && !in_counts) begin
      res_status_r <= ST_LOADED;
      res_bytes_r  <= 9'(MAX_LEN) + sum_r[8:0];
    end else if (cmd.take && is_bit) begin
      res_status_r <= ST_INVALID;
      res_bytes_r  <= '0;
    end else if (cmd.dec_b) begin
      res_status_r <= dec_hit ? ST_SYMBOL : ST_INVALID;
      res_bytes_r  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_symbol_r <= (res_status_r == ST_SYMBOL) ? rd_r : '0;
      out_bytes_r  <= res_bytes_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_symbol = out_symbol_r;
  assign out_bytes  = out_bytes_r;

endmodule

/* hw/rtl/jpeg_huffman_table_decoder_unit.sv */
// Top level of the JPEG canonical Huffman table loader and bit-serial decoder.
`timescale 1ns / 1ps
// Loads a JPEG Huffman table (16 length counts, then the symbols) and decodes
// coded bits MSB first, one bit per input transaction; one item is handled at
// a time. A count byte or a non-final symbol byte posts no result. The byte
// that completes a table starts the canonical code build, which walks the 16
// code lengths one per cycle before the result is posted. A table with more
// than 255 codes, or a coded bit with no valid table, goes straight to the
// emit step. A coded bit with a valid table goes through the per-length table
// lookup, the compare stage and the registered symbol memory read, and posts
// a result once it ends a code or misses. A waiting result does not block the
// next transaction until that transaction has a result of its own to post.
module jpeg_huffman_table_decoder_unit
  import jhtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] table_byte, [8] code_bit
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] symbol, [16:8] bytes_read
  output logic [1:0]  out_tuser   // [1:0] status
);

  cmd_t       cmd;
  sts_t       sts;
  status_t    out_status;
  logic [7:0] out_symbol;
  logic [8:0] out_bytes;

  jhtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jhtd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (in_tuser),
    .table_byte (in_tdata[7:0]),
    .code_bit   (in_tdata[8]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_status),
    .out_symbol (out_symbol),
    .out_bytes  (out_bytes)
  );

  assign out_tuser = out_status;
  assign out_tdata = {7'b0, out_bytes, out_symbol};

  // decode results never report a byte count
  a_dec_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_SYMBOL || out_tuser == ST_INVALID)
      |-> out_tdata[16:8] == 9'd0)
    else $error("decode result carries a byte count");

  // a rejected table always reports the 16 count bytes and no symbol
  a_reject_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_REJECTED
      |-> out_tdata[16:8] == 9'd16 && out_tdata[7:0] == 8'd0)
    else $error("rejected table result malformed");

  // a new result is posted only from the emit step, where input is held off
  a_post_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result posted while input was open");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the JPEG Huffman table loader and bit-serial decoder.
`timescale 1ns / 1ps
module testbench;
  import jhtd_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic       kind;
    logic [7:0] tbyte;
    logic       cbit;
  } huff_item_t;

  typedef struct {
    status_t    status;
    logic [7:0] symbol;
    logic [8:0] nbytes;
  } huff_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  huff_item_t   tx_items[$];
  huff_result_t pending_results[$];
  int n_sent = 0;
  int n_total = 1;
  int n_errors = 0;
  int n_cycles = 0;

  // Decoder state mirrored by the bench
  logic [7:0]  tbl_symbols[SYM_DEPTH];
  int unsigned len_fit[MAX_LEN];
  int unsigned len_end[MAX_LEN];
  int unsigned len_base[MAX_LEN];
  int unsigned load_pos = 0;
  int unsigned code_total = 0;
  int unsigned last_code = 0;
  int unsigned last_len = 0;
  bit          table_ok = 1'b0;
  int unsigned prefix_bits = 0;
  int unsigned prefix_len = 0;

  // Counts used while building stimulus tables
  int unsigned gen_counts[MAX_LEN];

  jpeg_huffman_table_decoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Assign canonical codes per length; drop the ones that no longer fit.
  function automatic void assign_codes();
    int unsigned code, idx, cap, n, fit, len;
    code = 0;
    idx = 0;
    last_code = 0;
    last_len = 0;
    for (len = 1; len <= MAX_LEN; len++) begin
      n = len_fit[len-1];
      cap = 1 << len;
      fit = 0;
      if (code < cap) fit = (n < cap - code) ? n : cap - code;
      if (fit > 0) begin
        last_code = (code + fit - 1) & 32'hFFFF;
        last_len = len;
      end
      len_base[len-1] = idx & 32'hFF;
      code += fit;
      len_end[len-1] = code;
      len_fit[len-1] = fit;
      idx += n;
      if (len < MAX_LEN) code = code << 1;
    end
    table_ok = 1'b1;
  endfunction

  function automatic bit huff_load_byte(input logic [7:0] b, output huff_result_t res);
    int unsigned sum, slot;
    res = '{ST_SYMBOL, 8'd0, 9'd0};
    if (load_pos == 0) begin
      table_ok = 1'b0;
      prefix_bits = 0;
      prefix_len = 0;
    end
    if (load_pos < MAX_LEN) begin
      len_fit[load_pos] = b;
      load_pos++;
      if (load_pos == MAX_LEN) begin
        sum = 0;
        foreach (len_fit[i]) sum += len_fit[i];
        if (sum > 255) begin
          load_pos = 0;
          code_total = 0;
          res = '{ST_REJECTED, 8'd0, 9'(MAX_LEN)};
          return 1'b1;
        end
        code_total = sum;
        if (sum == 0) begin
          load_pos = 0;
          assign_codes();
          res = '{ST_LOADED, 8'd0, 9'(MAX_LEN)};
          return 1'b1;
        end
      end
      return 1'b0;
    end
    slot = (load_pos - MAX_LEN) & 32'hFF;
    tbl_symbols[slot[7:0]] = b;
    load_pos++;
    if (slot + 1 >= code_total) begin
      load_pos = 0;
      assign_codes();
      res = '{ST_LOADED, 8'd0, 9'(MAX_LEN + code_total)};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit huff_decode_bit(input logic cbit, output huff_result_t res);
    int unsigned p, k, fit, maxc, start, slot, span_end;
    res = '{ST_INVALID, 8'd0, 9'd0};
    if (!table_ok) begin
      prefix_bits = 0;
      prefix_len = 0;
      return 1'b1;
    end
    p = ((prefix_bits << 1) | cbit) & 32'hFFFF;
    k = prefix_len + 1;
    if (k > MAX_LEN) k = MAX_LEN;
    fit = len_fit[k-1];
    maxc = len_end[k-1];
    start = maxc - fit;
    if (fit > 0 && p >= start && p < maxc) begin
      slot = (len_base[k-1] + (p - start)) & 32'hFF;
      prefix_bits = 0;
      prefix_len = 0;
      res = '{ST_SYMBOL, tbl_symbols[slot[7:0]], 9'd0};
      return 1'b1;
    end
    // End of the assigned code space, left-aligned to the longest length
    span_end = (last_len == 0) ? 0 : (last_code + 1) << (MAX_LEN - last_len);
    if (k >= MAX_LEN || (p << (MAX_LEN - k)) >= span_end) begin
      prefix_bits = 0;
      prefix_len = 0;
      return 1'b1;
    end
    prefix_bits = p;
    prefix_len = k;
    return 1'b0;
  endfunction

  function automatic bit huff_next_result(input huff_item_t it, output huff_result_t res);
    if (it.kind == KIND_TABLE) return huff_load_byte(it.tbyte, res);
    return huff_decode_bit(it.cbit, res);
  endfunction

  function automatic int sender_idle_pct();
    if (n_sent * 3 < n_total) return 31;
    if (n_sent * 3 < 2 * n_total) return 70;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_sent * 3 < n_total) return 70;
    if (n_sent * 3 < 2 * n_total) return 31;
    return 0;
  endfunction

  function automatic int unsigned count_sum();
    int unsigned sum;
    sum = 0;
    foreach (gen_counts[i]) sum += gen_counts[i];
    return sum;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    n_errors++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    tx_items.push_back('{KIND_TABLE, b, 1'($urandom)});
  endtask

  task automatic queue_bit(input logic b);
    tx_items.push_back('{KIND_BIT, 8'($urandom), b});
  endtask

  // Push counts and symbols from gen_counts; slip a coded bit in at stray_at.
  task automatic queue_table(input int stray_at, input logic [7:0] first_sym);
    int unsigned nsym;
    int pos;
    nsym = count_sum();
    if (nsym > 255) nsym = 0;
    pos = 0;
    foreach (gen_counts[i]) begin
      if (pos == stray_at) queue_bit(1'($urandom));
      queue_byte(8'(gen_counts[i]));
      pos++;
    end
    for (int unsigned s = 0; s < nsym; s++) begin
      if (pos == stray_at) queue_bit(1'($urandom));
      queue_byte(s == 0 ? first_sym : 8'($urandom_range(0, 255)));
      pos++;
    end
  endtask

  // Split leaves of a full tree at random, so every bit string decodes.
  task automatic grow_tree(input int splits);
    int cand[$];
    int pick;
    foreach (gen_counts[i]) gen_counts[i] = 0;
    gen_counts[0] = 2;
    repeat (splits) begin
      cand.delete();
      for (int l = 0; l < MAX_LEN - 1; l++)
        if (gen_counts[l] > 0) cand.push_back(l);
      if (cand.size() == 0) break;
      pick = cand[$urandom_range(0, cand.size() - 1)];
      gen_counts[pick]--;
      gen_counts[pick + 1] += 2;
    end
  endtask

  // Driver: present the next transaction once the current one is taken
  always @(posedge clk) begin
    huff_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        nxt = tx_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {7'd0, nxt.cbit, nxt.tbyte};
        in_tuser <= nxt.kind;
        n_sent++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check results, then predict from accepted inputs
  always @(posedge clk) begin
    huff_result_t want;
    huff_result_t got;
    huff_item_t   seen;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result with nothing expected: status %0d symbol %0d bytes %0d",
                           out_tuser, out_tdata[7:0], out_tdata[16:8]));
        end else begin
          want = pending_results.pop_front();
          if (out_tuser != want.status)
            report($sformatf("status %0d, expected %0d", out_tuser, want.status));
          if (out_tdata[7:0] != want.symbol)
            report($sformatf("symbol %0d, expected %0d", out_tdata[7:0], want.symbol));
          if (out_tdata[16:8] != want.nbytes)
            report($sformatf("bytes_read %0d, expected %0d", out_tdata[16:8], want.nbytes));
        end
      end
      if (in_tvalid && in_tready) begin
        seen = '{in_tuser, in_tdata[7:0], in_tdata[8]};
        if (huff_next_result(seen, got)) pending_results.push_back(got);
      end
    end
    out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("jpeg_huffman_table_decoder_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int n_directed;
    int pick;
    int idx;
    int unsigned room;
    foreach (tbl_symbols[i]) tbl_symbols[i] = '0;
    foreach (len_fit[i]) begin
      len_fit[i] = 0;
      len_end[i] = 0;
      len_base[i] = 0;
    end

    // Coded bit before any table exists
    queue_bit(1'b1);
    // Far too many codes: all counts at 0xFF
    foreach (gen_counts[i]) gen_counts[i] = 8'hFF;
    queue_table(-1, 8'h00);
    queue_bit(1'b0);
    // Empty table, then a bit that can match nothing
    foreach (gen_counts[i]) gen_counts[i] = 0;
    queue_table(-1, 8'h00);
    queue_bit(1'b1);
    // One length-1 code, three length-2 codes of which one is dropped;
    // a coded bit arrives in the middle of the load
    foreach (gen_counts[i]) gen_counts[i] = 0;
    gen_counts[0] = 1;
    gen_counts[1] = 3;
    queue_table(17, 8'hFF);
    queue_bit(1'b0);
    queue_bit(1'b1);
    queue_bit(1'b0);
    queue_bit(1'b1);
    queue_bit(1'b1);
    n_directed = tx_items.size();

    while (tx_items.size() < n_directed + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // Rejected table, sometimes exactly one code over the limit
        if ($urandom_range(0, 1) == 1) begin
          foreach (gen_counts[i]) gen_counts[i] = 16;
        end else begin
          foreach (gen_counts[i]) gen_counts[i] = $urandom_range(16, 255);
        end
        queue_table(-1, 8'h00);
      end else if (pick < 10) begin
        foreach (gen_counts[i]) gen_counts[i] = 0;
        queue_table(-1, 8'h00);
      end else begin
        grow_tree(pick < 14 ? $urandom_range(100, 253) : $urandom_range(0, 24));
        if ($urandom_range(0, 99) < 30) begin
          // Remove one code to open holes in the code space
          do idx = $urandom_range(0, MAX_LEN - 1); while (gen_counts[idx] == 0);
          gen_counts[idx]--;
        end
        if ($urandom_range(0, 99) < 20) begin
          // Overfill one length so some codes get dropped
          room = 255 - count_sum();
          idx = $urandom_range(0, MAX_LEN - 1);
          gen_counts[idx] += (room < 4) ? room : $urandom_range(1, 4);
        end
        queue_table($urandom_range(0, 99) < 10 ? $urandom_range(0, 40) : -1,
                    8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(8, 60)) queue_bit(1'($urandom_range(0, 1)));
    end
    n_total = tx_items.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (tx_items.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("jpeg_huffman_table_decoder_unit regression: pass");
    end else begin
      $display("jpeg_huffman_table_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
